// ===== hw/rtl/text_console_writer_unit_assert.svh =====
// Assertion macros for the text console writer.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TCW_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tcw assertion failed");
`define TCW_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tcw assertion failed");
`else
`define TCW_ASSERT_IMP(label, clk, rstn, ante, cons)
`define TCW_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== hw/rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam int MAX_COLS_DEFAULT = 128;
    localparam int MAX_ROWS_DEFAULT = 32;

    localparam int COLUMNS_W  = 8;
    localparam int ROWS_W     = 6;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'b1;

    localparam logic [COLUMNS_W-1:0] COLUMNS_RESET = 8'd80;
    localparam logic [ROWS_W-1:0]    ROWS_RESET    = 6'd25;

    localparam int CHAR_W      = 8;
    localparam int INDEX_W     = 12;
    localparam int COL_FIELD_W = 7;
    localparam int ROW_FIELD_W = 5;

    localparam logic             FUNC_READ    = 1'b1;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    typedef struct packed {
        logic               func;
        logic [CHAR_W-1:0]  char_code;
        logic [INDEX_W-1:0] read_index;
    } tcw_in_t;

    typedef struct packed {
        logic [COL_FIELD_W-1:0] cursor_col;
        logic [ROW_FIELD_W-1:0] cursor_row;
        logic                   scrolled;
        logic [CHAR_W-1:0]      read_char;
    } tcw_out_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RD,
        S_WR,
        S_SCR_COPY,
        S_SCR_CLEAR,
        S_OUT
    } tcw_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/text_console_writer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Text-mode console writer: a character store of MAX_COLS*MAX_ROWS cells in one
// synchronous RAM plus a cursor. An item either writes char_code at the cursor
// (newline, column wrap and scroll handled) or reads the cell at read_index.
// A read passes through the RAM read register and then the output register; a
// write that does not scroll moves the cursor and registers its result. A write
// that scrolls walks the screen one cell per cycle through the single read and
// single write port, taking no item meanwhile. After reset the RAM is cleared
// one cell per cycle, all MAX_COLS*MAX_ROWS cells (4096 at the defaults), before
// the first item is taken; configuration writes are taken at any time the block
// is idle. A new item is taken while a finished result still waits on the result
// channel. Columns of 0 count as 1; values above MAX_COLS/MAX_ROWS are clamped.

`include "text_console_writer_unit_assert.svh"

module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEFAULT,
    parameter int MAX_ROWS = MAX_ROWS_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire tcw_in_t               s_payload,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output tcw_out_t                   m_payload,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int PW    = $clog2(CELLS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);

    // configuration
    logic [COLUMNS_W-1:0] columns_reg;
    logic [ROWS_W-1:0]    rows_reg;
    logic [CW-1:0]        ncols;
    logic [RW-1:0]        nrows;
    logic [PW-1:0]        total_reg;

    // control and cursor
    tcw_state_t     state_reg, state_next;
    logic [CW-1:0]  cur_col_reg, cur_col_next;
    logic [RW-1:0]  cur_row_reg, cur_row_next;
    logic [PW-1:0]  scr_rd_reg, scr_rd_next;
    logic [PW-1:0]  scr_wr_reg, scr_wr_next;
    logic           pend_reg, pend_next;
    logic           m_valid_reg, m_valid_next;

    // payload
    logic [CHAR_W-1:0] code_reg, code_next;
    logic              idx_ok_reg, idx_ok_next;
    tcw_out_t          res_reg, res_next;
    tcw_out_t          m_payload_reg, m_payload_next;

    // RAM ports
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [CHAR_W-1:0] mem_rdata;

    // write step
    logic [CW-1:0] col_c, col_n;
    logic [RW-1:0] row_c, row_n;
    logic          scroll;
    logic          fin;
    tcw_out_t      fin_data;
    logic          slot_free;

    tcw_char_ram #(
        .DEPTH (CELLS)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= COLUMNS_RESET;
            rows_reg    <= ROWS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_COLUMNS: columns_reg <= cfg_wdata[COLUMNS_W-1:0];
                CFG_ROWS:    rows_reg    <= cfg_wdata[ROWS_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        if (columns_reg == '0) begin
            ncols = CW'(1);
        end else if (int'(columns_reg) > MAX_COLS) begin
            ncols = CW'(MAX_COLS);
        end else begin
            ncols = CW'(columns_reg);
        end
        if (rows_reg == '0) begin
            nrows = RW'(1);
        end else if (int'(rows_reg) > MAX_ROWS) begin
            nrows = RW'(MAX_ROWS);
        end else begin
            nrows = RW'(rows_reg);
        end
    end

    // screen size in cells, the end of a scroll pass
    always_ff @(posedge aclk) begin
        total_reg <= PW'(ncols) * PW'(nrows);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            scr_rd_reg  <= '0;
            scr_wr_reg  <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            scr_rd_reg  <= scr_rd_next;
            scr_wr_reg  <= scr_wr_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg      <= code_next;
        idx_ok_reg    <= idx_ok_next;
        res_reg       <= res_next;
        m_payload_reg <= m_payload_next;
    end

    // cursor step of a write, clamped to the screen first
    always_comb begin
        col_c = (cur_col_reg >= ncols) ? ncols - CW'(1) : cur_col_reg;
        row_c = (cur_row_reg >= nrows) ? nrows - RW'(1) : cur_row_reg;
        if (code_reg == NEWLINE_CODE) begin
            col_n = '0;
            row_n = row_c + RW'(1);
        end else begin
            col_n = col_c + CW'(1);
            row_n = row_c;
        end
        if (col_n == ncols) begin
            col_n = '0;
            row_n = row_c + RW'(1);
        end
        scroll = (row_n == nrows);
        if (scroll) begin
            row_n = nrows - RW'(1);
        end
    end

    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        scr_rd_next    = scr_rd_reg;
        scr_wr_next    = scr_wr_reg;
        pend_next      = pend_reg;
        code_next      = code_reg;
        idx_ok_next    = idx_ok_reg;
        res_next       = res_reg;
        m_payload_next = m_payload_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        s_ready        = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = AW'(scr_wr_reg);
        mem_wdata      = '0;
        mem_raddr      = AW'(s_payload.read_index);
        fin            = 1'b0;
        fin_data       = res_reg;

        case (state_reg)
            S_INIT: begin
                mem_we      = 1'b1;
                scr_wr_next = scr_wr_reg + PW'(1);
                if (scr_wr_reg == PW'(CELLS - 1)) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    code_next   = s_payload.char_code;
                    idx_ok_next = (int'(s_payload.read_index) < CELLS);
                    state_next  = (s_payload.func == FUNC_READ) ? S_RD : S_WR;
                end
            end

            S_RD: begin
                fin                 = 1'b1;
                fin_data.cursor_col = COL_FIELD_W'(cur_col_reg);
                fin_data.cursor_row = ROW_FIELD_W'(cur_row_reg);
                fin_data.scrolled   = 1'b0;
                fin_data.read_char  = idx_ok_reg ? mem_rdata : '0;
            end

            S_WR: begin
                mem_we    = (code_reg != NEWLINE_CODE);
                mem_waddr = AW'(PW'(row_c) * PW'(ncols) + PW'(col_c));
                mem_wdata = code_reg;
                cur_col_next = col_n;
                cur_row_next = row_n;
                fin_data.cursor_col = COL_FIELD_W'(col_n);
                fin_data.cursor_row = ROW_FIELD_W'(row_n);
                fin_data.scrolled   = scroll;
                fin_data.read_char  = '0;
                if (scroll) begin
                    res_next    = fin_data;
                    scr_rd_next = PW'(ncols);
                    scr_wr_next = '0;
                    pend_next   = 1'b0;
                    state_next  = S_SCR_COPY;
                end else begin
                    fin = 1'b1;
                end
            end

            S_SCR_COPY: begin
                // read one row ahead, write the word read last cycle
                mem_we    = pend_reg;
                mem_wdata = mem_rdata;
                if (pend_reg) begin
                    scr_wr_next = scr_wr_reg + PW'(1);
                end
                mem_raddr = AW'(scr_rd_reg);
                if (scr_rd_reg < total_reg) begin
                    scr_rd_next = scr_rd_reg + PW'(1);
                    pend_next   = 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    state_next = S_SCR_CLEAR;
                end
            end

            S_SCR_CLEAR: begin
                mem_we      = 1'b1;
                scr_wr_next = scr_wr_reg + PW'(1);
                if (scr_wr_reg == total_reg - PW'(1)) begin
                    fin = 1'b1;
                end
            end

            S_OUT: begin
                if (slot_free) begin
                    m_payload_next = res_reg;
                    m_valid_next   = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // hand the result on, or park it until the output register frees up
        if (fin) begin
            if (slot_free) begin
                m_payload_next = fin_data;
                m_valid_next   = 1'b1;
                state_next     = S_IDLE;
            end else begin
                res_next   = fin_data;
                state_next = S_OUT;
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    `TCW_ASSERT_NXT(a_item_takes_two, aclk, aresetn, s_valid && s_ready, !s_ready)
    `TCW_ASSERT_NXT(a_cursor_on_screen, aclk, aresetn, state_reg == S_WR, (cur_col_reg < ncols) && (cur_row_reg < nrows))
    `TCW_ASSERT_IMP(a_copy_write_behind, aclk, aresetn, state_reg == S_SCR_COPY, scr_wr_reg < scr_rd_reg)

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_char_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcw_char_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH = MAX_COLS_DEFAULT * MAX_ROWS_DEFAULT,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [CHAR_W-1:0] wdata,
    input  wire logic [AW-1:0]     raddr,
    output logic      [CHAR_W-1:0] rdata
);

    logic [CHAR_W-1:0] char_mem [DEPTH];
    logic [CHAR_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            char_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= char_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== tb/text_console_checker.sv =====
`timescale 1ns / 1ps

module text_console_checker
    import tcw_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEFAULT,
    parameter int MAX_ROWS = MAX_ROWS_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire tcw_in_t               s_payload,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire tcw_out_t              m_payload,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                         error_count,
    output int                         outstanding
);

    localparam int CELLS = MAX_COLS * MAX_ROWS;

    logic [CHAR_W-1:0]    screen [CELLS];
    int                   cur_col;
    int                   cur_row;
    logic [COLUMNS_W-1:0] columns_reg;
    logic [ROWS_W-1:0]    rows_reg;
    tcw_out_t             pending_results [$];

    function automatic int active_dim(input int v, input int maxv);
        if (v == 0)
            return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic void scroll_rows_up(input int ncols, input int nrows);
        int moved;
        moved = ncols * (nrows - 1);
        for (int i = 0; i < moved; i++)
            screen[i] = screen[i + ncols];
        for (int i = moved; i < ncols * nrows; i++)
            screen[i] = '0;
    endfunction

    function automatic tcw_out_t apply_console_item(input tcw_in_t it);
        tcw_out_t res;
        int       ncols;
        int       nrows;
        res = '0;
        if (it.func == FUNC_READ) begin
            if (int'(it.read_index) < CELLS)
                res.read_char = screen[it.read_index];
        end else begin
            ncols = active_dim(int'(columns_reg), MAX_COLS);
            nrows = active_dim(int'(rows_reg), MAX_ROWS);
            // pull a cursor left outside a shrunken screen back onto it
            if (cur_col >= ncols)
                cur_col = ncols - 1;
            if (cur_row >= nrows)
                cur_row = nrows - 1;
            if (it.char_code == NEWLINE_CODE) begin
                cur_row++;
                cur_col = 0;
            end else begin
                screen[cur_row * ncols + cur_col] = it.char_code;
                cur_col++;
            end
            if (cur_col == ncols) begin
                cur_col = 0;
                cur_row++;
            end
            if (cur_row == nrows) begin
                scroll_rows_up(ncols, nrows);
                cur_row--;
                res.scrolled = 1'b1;
            end
        end
        res.cursor_col = cur_col[COL_FIELD_W-1:0];
        res.cursor_row = cur_row[ROW_FIELD_W-1:0];
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin : monitor
        tcw_out_t want;
        if (!aresetn) begin
            for (int i = 0; i < CELLS; i++)
                screen[i] = '0;
            cur_col = 0;
            cur_row = 0;
            columns_reg = COLUMNS_RESET;
            rows_reg = ROWS_RESET;
            error_count = 0;
            pending_results.delete();
        end else begin
            // compare before queuing: a result never belongs to this cycle's transfer
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with no pending item");
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("cursor_col", 8'(want.cursor_col), 8'(m_payload.cursor_col));
                    check_field("cursor_row", 8'(want.cursor_row), 8'(m_payload.cursor_row));
                    check_field("scrolled", 8'(want.scrolled), 8'(m_payload.scrolled));
                    check_field("read_char", want.read_char, m_payload.read_char);
                end
            end
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_COLUMNS)
                    columns_reg = cfg_wdata[COLUMNS_W-1:0];
                else if (cfg_addr == CFG_ROWS)
                    rows_reg = cfg_wdata[ROWS_W-1:0];
            end
            if (s_valid && s_ready)
                pending_results.push_back(apply_console_item(s_payload));
        end
        outstanding <= pending_results.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import tcw_pkg::*;

    localparam int   LIMIT_CYCLES = 2_000_000;
    localparam int   RANDOM_ITEMS = 1300;
    localparam logic FUNC_WRITE   = ~FUNC_READ;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    tcw_in_t               s_payload = '0;
    logic                  m_ready   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = CFG_COLUMNS;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    wire logic             s_ready;
    wire logic             m_valid;
    tcw_out_t              m_payload;

    int err_total;
    int pending;
    int cycle_count = 0;
    int stall_left  = 0;
    bit calm        = 1'b0;

    text_console_writer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    text_console_checker chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .error_count(err_total),
        .outstanding(pending)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    task automatic send_item(input tcw_in_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] code);
        tcw_in_t it;
        it.func = FUNC_WRITE;
        it.char_code = code;
        it.read_index = INDEX_W'($urandom_range(0, 4095));
        send_item(it);
    endtask

    task automatic read_cell(input logic [INDEX_W-1:0] idx);
        tcw_in_t it;
        it.func = FUNC_READ;
        it.char_code = CHAR_W'($urandom_range(0, 255));
        it.read_index = idx;
        send_item(it);
    endtask

    // drop valid and hold until every result has been taken
    task automatic wait_results_done();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic set_screen(input logic [7:0] cols, input logic [7:0] rws);
        cfg_wr_en <= 1'b1;
        cfg_addr <= CFG_COLUMNS;
        cfg_wdata <= cols;
        @(posedge aclk);
        cfg_addr <= CFG_ROWS;
        cfg_wdata <= rws;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic tcw_in_t rand_item(input int cells);
        tcw_in_t it;
        int      r;
        it.func = FUNC_WRITE;
        it.char_code = CHAR_W'($urandom_range(0, 255));
        it.read_index = INDEX_W'($urandom_range(0, 4095));
        r = $urandom_range(0, 99);
        if (r < 25) begin
            it.func = FUNC_READ;
            // favor cells on the visible screen
            if ($urandom_range(0, 3) != 0)
                it.read_index = INDEX_W'($urandom_range(0, cells - 1));
        end else if (r < 45) begin
            it.char_code = NEWLINE_CODE;
        end
        return it;
    endfunction

    initial begin
        logic [7:0] cols_val;
        logic [7:0] rows_val;
        int         ncols;
        int         nrows;
        int         cells;
        int         n_items;
        int         sent;
        bit         first;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // power-up geometry
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h41);
        put_char(NEWLINE_CODE);
        read_cell(12'd0);
        read_cell(12'd1);
        read_cell(12'hFFF);
        wait_results_done();

        // zero registers act as a single cell: cursor row clamps, every write scrolls
        set_screen(8'd0, 8'd0);
        read_cell(12'd0);
        put_char(8'h41);
        put_char(NEWLINE_CODE);
        read_cell(12'd0);
        wait_results_done();

        // oversized registers clamp to the full store
        set_screen(8'd255, 8'd63);
        put_char(NEWLINE_CODE);
        put_char(8'h55);
        put_char(8'hAA);
        put_char(8'h7E);
        read_cell(12'd128);
        wait_results_done();

        // shrink under the cursor: column clamps, then wrap into a scroll
        set_screen(8'd3, 8'd2);
        put_char(8'h78);
        put_char(8'h79);
        put_char(8'h7A);
        read_cell(12'd0);
        read_cell(12'd2);

        sent = 0;
        first = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            wait_results_done();
            if (first) begin
                cols_val = 8'd128;
                rows_val = 8'd32;
                first = 1'b0;
            end else begin
                case ($urandom_range(0, 9))
                    0: begin
                        cols_val = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd128;
                        rows_val = ($urandom_range(0, 1) != 0) ? 8'd63 : 8'd32;
                    end
                    1: begin
                        cols_val = 8'($urandom_range(0, 1));
                        rows_val = 8'($urandom_range(0, 1));
                    end
                    default: begin
                        cols_val = 8'($urandom_range(1, 24));
                        rows_val = 8'($urandom_range(1, 10));
                    end
                endcase
            end
            set_screen(cols_val, rows_val);
            ncols = (cols_val == 0) ? 1 : (cols_val > MAX_COLS_DEFAULT) ? MAX_COLS_DEFAULT
                                                                         : cols_val;
            nrows = (rows_val == 0) ? 1 : (rows_val > MAX_ROWS_DEFAULT) ? MAX_ROWS_DEFAULT
                                                                         : rows_val;
            cells = ncols * nrows;
            // big screens scroll slowly, keep those phases short
            n_items = (cells > 512) ? 12 : 95;
            calm = ($urandom_range(0, 3) == 0);
            repeat (n_items) begin
                if ($urandom_range(0, 199) == 0)
                    wait_results_done();
                send_item(rand_item(cells));
                sent++;
            end
        end

        wait_results_done();
        repeat (20) @(posedge aclk);
        if (err_total == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
